/* src/abna_pkg.sv */
// abna_pkg: shared widths, register indexes, stage record and reciprocal table
// for the alpha bleed neighbour average block. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abna_pkg;

	localparam int PIX_W = 32;
	localparam int CFG_W = 12;
	localparam int ROW_W = 12;
	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int RCP_W = 17;
	localparam int RCP_SHIFT = 16;

	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	localparam logic [ROW_W-1:0] HEIGHT_LIMIT = 12'd2048;

	typedef struct packed {
		logic             pass;
		logic [PIX_W-1:0] centre;
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
		logic [CNT_W-1:0] count;
	} calc_t;

	// ceil(2^16 / n); exact floor quotient for sums far below 2^16 / n
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/alpha_bleed_neighbour_average_core.sv */
// alpha_bleed_neighbour_average_core: streaming 3x3 alpha bleed over rgba pixels
// line store memory, 3x3 window, position counters and reciprocal divide
// depends on abna_pkg
//
// usage
//   s_* carries items: s_tuser = 0 a pixel in s_tdata, s_tuser = 1 a drain tick
//   m_* carries processed pixels in m_tdata, m_tlast marks the frame's final pixel
//   cfg_wr_en writes image_width (index 0) or image_height (index 1); a write
//   restarts the frame; the user must do it only while the block is idle, which
//   the block itself does not enforce; results trail the input by one row plus
//   one pixel; after the last pixel one drain tick per pending result flushes
//   the frame; a pixel that yields a result passes accept, line store
//   read-modify-write, window sum and reciprocal multiply into the output
//   register, in that order; a pixel without a result takes only the accept
//   and the read-modify-write, an ignored item only the accept, and the first
//   drain tick of a single-row frame adds an extra line store read-modify-write
//   a stalled receiver holds the result in the output register; the next item
//   is still taken and waits only at the final step
//   after reset the sizes are 2048 x 2048 and all counters and the window are
//   cleared; the line store is not cleared, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module alpha_bleed_neighbour_average_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [abna_pkg::PIX_W-1:0]      s_tdata,   // pixel_in
	input  wire logic                            s_tuser,   // op
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [abna_pkg::PIX_W-1:0]           m_tdata,   // pixel_out
	output logic                                 m_tlast,   // frame_last
	input  wire logic                            cfg_wr_en,
	input  wire logic                            cfg_index,
	input  wire logic [abna_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int CMPW = (AW + 1 > abna_pkg::CFG_W) ? AW + 1 : abna_pkg::CFG_W;
	localparam int PW   = abna_pkg::PIX_W;
	localparam int RW   = abna_pkg::ROW_W;
	localparam int PRW  = abna_pkg::SUM_W + abna_pkg::RCP_W;
	localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_CALC  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                 state_q;
	logic [abna_pkg::CFG_W-1:0] width_q;
	logic [abna_pkg::CFG_W-1:0] height_q;
	logic [AW-1:0]              in_col_q;
	logic [RW-1:0]              in_row_q;
	logic [AW-1:0]              out_col_q;
	logic [RW-1:0]              out_row_q;
	logic [PW-1:0]              win_q [9];
	logic [PW-1:0]              pix_q;
	logic                       produce_q;
	logic                       extra_q;
	abna_pkg::calc_t            calc_q;

	logic [2*PW-1:0]            line_mem [MAX_WIDTH];
	logic [2*PW-1:0]            rdata_q;
	logic                       rd_en;
	logic                       wr_en;

	logic [CMPW-1:0]            w_ext;
	logic [CMPW-1:0]            w_used;
	logic [RW-1:0]              h_used;
	logic [CMPW-1:0]            in_col_inc;
	logic [CMPW-1:0]            out_col_inc;
	logic                       in_wrap;
	logic                       out_wrap;
	logic [RW-1:0]              out_row_inc;
	logic                       frame_end;
	logic                       accept;
	logic                       pix_ok;
	logic                       drain_ok;
	abna_pkg::calc_t            calc_d;
	logic [PRW-1:0]             prod_r;
	logic [PRW-1:0]             prod_g;
	logic [PRW-1:0]             prod_b;
	logic [PW-1:0]              result;
	logic                       out_free;

	// sizes clamped to the supported range
	assign w_ext  = CMPW'(width_q);
	assign w_used = (w_ext == '0) ? CMPW'(1) : ((w_ext > MAXW_C) ? MAXW_C : w_ext);
	assign h_used = (height_q == '0) ? RW'(1) :
		((height_q > abna_pkg::HEIGHT_LIMIT) ? abna_pkg::HEIGHT_LIMIT : height_q);

	assign in_col_inc  = CMPW'(in_col_q) + CMPW'(1);
	assign out_col_inc = CMPW'(out_col_q) + CMPW'(1);
	assign in_wrap     = (in_col_inc >= w_used);
	assign out_wrap    = (out_col_inc >= w_used);
	assign out_row_inc = out_row_q + RW'(1);
	assign frame_end   = out_wrap && (out_row_inc >= h_used);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign pix_ok   = !s_tuser && (in_row_q < h_used);
	assign drain_ok = s_tuser && (in_row_q >= h_used) && (out_row_q < h_used);

	assign rd_en = (accept && (pix_ok || drain_ok)) || (state_q == ST_READ);
	assign wr_en = (state_q == ST_SHIFT);

	// line store: entry holds {row above, current row} of one column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= line_mem[in_col_q];
		end
		if (wr_en) begin
			line_mem[in_col_q] <= {rdata_q[PW-1:0], pix_q};
		end
	end

	// neighbour sums over the edge-clipped window, counting only pixels with nonzero alpha
	always_comb begin
		logic [2:0] row_ok;
		logic [2:0] col_ok;
		logic [PW-1:0] p;
		calc_d        = '0;
		row_ok        = {out_row_inc < h_used, 1'b1, out_row_q != '0};
		col_ok        = {!out_wrap, 1'b1, out_col_q != '0};
		calc_d.centre = win_q[4];
		calc_d.pass   = (win_q[4][31:24] != 8'd0);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p = win_q[i * 3 + j];
				if (row_ok[i] && col_ok[j] && (p[31:24] != 8'd0)) begin
					calc_d.sum_r = calc_d.sum_r + abna_pkg::SUM_W'(p[7:0]);
					calc_d.sum_g = calc_d.sum_g + abna_pkg::SUM_W'(p[15:8]);
					calc_d.sum_b = calc_d.sum_b + abna_pkg::SUM_W'(p[23:16]);
					calc_d.count = calc_d.count + abna_pkg::CNT_W'(1);
				end
			end
		end
	end

	// floor average by reciprocal multiply; a zero count gives zero
	assign prod_r = PRW'(calc_q.sum_r) * PRW'(abna_pkg::recip(calc_q.count));
	assign prod_g = PRW'(calc_q.sum_g) * PRW'(abna_pkg::recip(calc_q.count));
	assign prod_b = PRW'(calc_q.sum_b) * PRW'(abna_pkg::recip(calc_q.count));
	assign result = calc_q.pass ? calc_q.centre :
		{8'd0, prod_b[abna_pkg::RCP_SHIFT +: 8], prod_g[abna_pkg::RCP_SHIFT +: 8],
			prod_r[abna_pkg::RCP_SHIFT +: 8]};

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			calc_q <= calc_d;
		end
		if (accept) begin
			pix_q <= s_tuser ? '0 : s_tdata;
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata <= result;
			m_tlast <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			width_q   <= 12'd2048;
			height_q  <= 12'd2048;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			produce_q <= 1'b0;
			extra_q   <= 1'b0;
			m_tvalid  <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					abna_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_wdata;
					abna_pkg::CFG_IDX_HEIGHT: height_q <= cfg_wdata;
					default:                  height_q <= cfg_wdata;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				for (int i = 0; i < 9; i++) begin
					win_q[i] <= '0;
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept && pix_ok) begin
							produce_q <= !((in_row_q == '0) ||
								((in_row_q == RW'(1)) && (in_col_q == '0)));
							extra_q   <= 1'b0;
							state_q   <= ST_SHIFT;
						end else if (accept && drain_ok) begin
							produce_q <= 1'b1;
							// single-row frame: first drain pushes two columns
							extra_q   <= (h_used == RW'(1)) && (out_row_q == '0) &&
								(out_col_q == '0);
							state_q   <= ST_SHIFT;
						end
					end
					ST_READ: begin
						state_q <= ST_SHIFT;
					end
					ST_SHIFT: begin
						for (int i = 0; i < 3; i++) begin
							win_q[i * 3]     <= win_q[i * 3 + 1];
							win_q[i * 3 + 1] <= win_q[i * 3 + 2];
						end
						win_q[2] <= rdata_q[2*PW-1:PW];
						win_q[5] <= rdata_q[PW-1:0];
						win_q[8] <= pix_q;
						if (in_wrap) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + RW'(1);
						end else begin
							in_col_q <= in_col_inc[AW-1:0];
						end
						if (extra_q) begin
							extra_q <= 1'b0;
							state_q <= ST_READ;
						end else if (produce_q) begin
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_CALC: begin
						state_q <= ST_OUT;
					end
					ST_OUT: begin
						if (out_free) begin
							m_tvalid <= 1'b1;
							state_q  <= ST_IDLE;
							if (frame_end) begin
								in_col_q  <= '0;
								in_row_q  <= '0;
								out_col_q <= '0;
								out_row_q <= '0;
								for (int i = 0; i < 9; i++) begin
									win_q[i] <= '0;
								end
							end else if (out_wrap) begin
								out_col_q <= '0;
								out_row_q <= out_row_inc;
							end else begin
								out_col_q <= out_col_inc[AW-1:0];
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* src/abna_checker.sv */
// abna_checker: port-level checks for alpha_bleed_neighbour_average_core
// bound to the top level below; depends on abna_pkg
`timescale 1ns / 1ps
`default_nettype none

module abna_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       s_tvalid,
	input wire logic                       s_tready,
	input wire logic                       m_tvalid,
	input wire logic                       m_tready,
	input wire logic [abna_pkg::PIX_W-1:0] m_tdata,
	input wire logic                       m_tlast
);

	// output stays silent while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a fresh result never directly follows an input transfer; the input must first pass the shift, calc and out states
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready, 1) &&
			!$past(s_tvalid && s_tready, 2))
		else $error("result appeared too soon after an input transfer");

endmodule

bind alpha_bleed_neighbour_average_core abna_checker u_abna_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
